FILE: hw/rtl/dap_pkg.sv
`timescale 1ns / 1ps

package dap_pkg;

  localparam int unsigned DEF_MAX_ADD_DAYS = 65535;
  localparam int unsigned YEAR_TOP         = 16383;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned YEARI_W = YEAR_W + 1;  // holds one year past the top
  localparam int unsigned ADD_W   = 16;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned C100_W  = 7;
  localparam int unsigned CENT_W  = 8;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 24;

  // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every y below 2**15
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned MUL_W        = YEARI_W + 13;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV    = 7'b0000010,
    ST_REM    = 7'b0000100,
    ST_NORM   = 7'b0001000,
    ST_YEAR   = 7'b0010000,
    ST_MONTH  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic norm;
    logic year_step;
    logic month_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_year;
    logic year_ovf;
    logic year_fits;
    logic month_fits;
  } status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/dap_ctrl.sv
`timescale 1ns / 1ps

module dap_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dap_pkg::status_t status_i,
  output dap_pkg::cmd_t    cmd_o
);
  import dap_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_NORM;
      end
      ST_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = status_i.in_year ? ST_MONTH : ST_YEAR;
      end
      ST_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (status_i.year_ovf) begin
          state_d = ST_FINISH;
        end else if (status_i.year_fits) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (status_i.month_fits) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output slot, then hand the result over
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/dap_datapath.sv
`timescale 1ns / 1ps

module dap_datapath #(
  parameter int unsigned MAX_ADD_DAYS = dap_pkg::DEF_MAX_ADD_DAYS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dap_pkg::cmd_t                 cmd_i,
  output dap_pkg::status_t              status_o,
  input  logic [dap_pkg::DAY_W-1:0]     start_day_i,
  input  logic [dap_pkg::MONTH_W-1:0]   start_month_i,
  input  logic [dap_pkg::YEAR_W-1:0]    start_year_i,
  input  logic [dap_pkg::ADD_W-1:0]     days_to_add_i,
  output logic [dap_pkg::DAY_W-1:0]     new_day_o,
  output logic [dap_pkg::MONTH_W-1:0]   new_month_o,
  output logic [dap_pkg::YEAR_W-1:0]    new_year_o,
  output logic                          year_overflow_o
);
  import dap_pkg::*;

  localparam int unsigned NW = $clog2(MAX_ADD_DAYS + 1);
  localparam int unsigned CW = (NW > DOY_W) ? NW : DOY_W;

  logic [MONTH_W-1:0] m_q;
  logic [DAY_W-1:0]   d_q;
  logic [YEARI_W-1:0] y_q;
  logic [NW-1:0]      n_q;
  logic [DOY_W-1:0]   doy_q;
  logic [CENT_W-1:0]  cent_q;
  logic [C100_W-1:0]  c100_q;
  logic [1:0]         cmod_q;
  logic               ovf_q;

  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [YEAR_W-1:0]  year_q;
  logic               yovf_q;

  logic [MUL_W-1:0]   prod;
  logic [YEARI_W-1:0] cent_x100;
  logic               leap;
  logic [DOY_W-1:0]   ylen;
  logic [DAY_W-1:0]   ml;
  logic [DAY_W-1:0]   d_clamp;
  logic [DOY_W-1:0]   doy0;
  logic [DOY_W-1:0]   rest_y;
  logic [CW-1:0]      n_x;
  logic [CW-1:0]      rest_x;
  logic [CW-1:0]      ylen_x;
  logic [MONTH_W-1:0] m_in;
  logic [NW-1:0]      n_in;

  assign prod      = MUL_W'(y_q) * MUL_W'(DIV100_MUL);
  assign cent_x100 = YEARI_W'(cent_q) * YEARI_W'(100);

  assign leap = ((y_q[1:0] == 2'd0) && (c100_q != '0)) || ((c100_q == '0) && (cmod_q == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign ml   = month_len(m_q, leap);

  assign d_clamp = (d_q > ml) ? ml : d_q;
  assign doy0    = days_before(m_q) + DOY_W'(leap && (m_q > MONTH_FEB)) + DOY_W'(d_clamp);
  assign rest_y  = ylen - doy0;
  assign n_x     = CW'(n_q);
  assign rest_x  = CW'(rest_y);
  assign ylen_x  = CW'(ylen);

  always_comb begin
    if (start_month_i == '0) begin
      m_in = MONTH_JAN;
    end else if (start_month_i > MONTH_DEC) begin
      m_in = MONTH_DEC;
    end else begin
      m_in = start_month_i;
    end
  end

  assign n_in = (32'(days_to_add_i) > 32'(MAX_ADD_DAYS)) ? NW'(MAX_ADD_DAYS) : NW'(days_to_add_i);

  assign status_o.in_year    = (n_x <= rest_x);
  assign status_o.year_ovf   = y_q[YEARI_W-1];
  assign status_o.year_fits  = (n_x < ylen_x);
  assign status_o.month_fits = (doy_q <= DOY_W'(ml));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q   <= (start_day_i == '0) ? DAY_W'(1) : start_day_i;
      m_q   <= m_in;
      y_q   <= (start_year_i == '0) ? YEARI_W'(1) : YEARI_W'(start_year_i);
      n_q   <= n_in;
      ovf_q <= 1'b0;
    end
    if (cmd_i.div) begin
      cent_q <= prod[DIV100_SHIFT +: CENT_W];
    end
    if (cmd_i.rem) begin
      c100_q <= C100_W'(y_q - cent_x100);
      cmod_q <= cent_q[1:0];
    end
    if (cmd_i.norm) begin
      m_q <= MONTH_JAN;
      if (status_o.in_year) begin
        doy_q <= doy0 + DOY_W'(n_q);
      end else begin
        // move to the first of January of the next year
        n_q <= NW'(n_x - rest_x - CW'(1));
        y_q <= y_q + YEARI_W'(1);
        if (c100_q == C100_W'(99)) begin
          c100_q <= '0;
          cmod_q <= cmod_q + 2'd1;
        end else begin
          c100_q <= c100_q + C100_W'(1);
        end
      end
    end
    if (cmd_i.year_step) begin
      if (status_o.year_ovf) begin
        ovf_q <= 1'b1;
      end else if (status_o.year_fits) begin
        doy_q <= DOY_W'(n_x) + DOY_W'(1);
      end else begin
        n_q <= NW'(n_x - ylen_x);
        y_q <= y_q + YEARI_W'(1);
        if (c100_q == C100_W'(99)) begin
          c100_q <= '0;
          cmod_q <= cmod_q + 2'd1;
        end else begin
          c100_q <= c100_q + C100_W'(1);
        end
      end
    end
    if (cmd_i.month_step && !status_o.month_fits) begin
      doy_q <= doy_q - DOY_W'(ml);
      m_q   <= m_q + MONTH_W'(1);
    end
    if (cmd_i.out_load) begin
      day_q   <= ovf_q ? DAY_W'(31) : doy_q[DAY_W-1:0];
      month_q <= ovf_q ? MONTH_DEC : m_q;
      year_q  <= ovf_q ? YEAR_W'(YEAR_TOP) : y_q[YEAR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yovf_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      yovf_q <= ovf_q;
    end
  end

  assign new_day_o       = day_q;
  assign new_month_o     = month_q;
  assign new_year_o      = year_q;
  assign year_overflow_o = yovf_q;

endmodule

FILE: hw/rtl/date_add_days.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  start date and day count
// m_axis    out        m_axis_tvalid/m_axis_tready  resulting date and overflow flag
//
// One item at a time: setup (load, divide, remainder, normalise), then one whole
// year stepped per pass (up to about 180), one month walked per pass in the final
// year (up to 12), then the hand-off. The year loop in the datapath sets the latency.
// Reset clears the state machine and the output valid; no clearing pass.
// A held result stalls only the final hand-off; the next item is taken meanwhile.

module date_add_days #(
  parameter int unsigned MAX_ADD_DAYS = dap_pkg::DEF_MAX_ADD_DAYS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23], zero[39]
  input  logic [dap_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // new_day[4:0], new_month[8:5], new_year[22:9], year_overflow[23]
  output logic [dap_pkg::OUT_W-1:0]  m_axis_tdata
);
  import dap_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [DAY_W-1:0]   new_day;
  logic [MONTH_W-1:0] new_month;
  logic [YEAR_W-1:0]  new_year;
  logic               year_overflow;

  dap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dap_datapath #(
    .MAX_ADD_DAYS (MAX_ADD_DAYS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .start_day_i     (s_axis_tdata[4:0]),
    .start_month_i   (s_axis_tdata[8:5]),
    .start_year_i    (s_axis_tdata[22:9]),
    .days_to_add_i   (s_axis_tdata[38:23]),
    .new_day_o       (new_day),
    .new_month_o     (new_month),
    .new_year_o      (new_year),
    .year_overflow_o (year_overflow)
  );

  assign m_axis_tdata = {year_overflow, new_year, new_month, new_day};

  // one item in flight: taking an item closes the input until it is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |->
      (m_axis_tdata[22:9] == YEAR_W'(YEAR_TOP)) && (m_axis_tdata[8:5] == MONTH_DEC)
      && (m_axis_tdata[4:0] == DAY_W'(31)))
    else $error("overflow result not saturated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:5] != '0) && (m_axis_tdata[8:5] <= MONTH_DEC)
      && (m_axis_tdata[4:0] != '0))
    else $error("result date out of range");

endmodule

FILE: tb/date_add_checker.sv
`timescale 1ns / 1ps

module date_add_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23], zero[39]
  input  logic [dap_pkg::IN_W-1:0]  in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  // new_day[4:0], new_month[8:5], new_year[22:9], year_overflow[23]
  input  logic [dap_pkg::OUT_W-1:0] out_data_i,
  output int unsigned               error_count_o,
  output int unsigned               outstanding_o
);
  import dap_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic               zero;
    logic [ADD_W-1:0]   count;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_req_t;

  typedef struct packed {
    logic               ovf;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_res_t;

  date_res_t   expected_dates[$];
  date_req_t   start_dates[$];
  date_res_t   got;
  date_res_t   want;
  date_req_t   req;
  int unsigned errors = 0;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      2:             len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // walk the count off month by month
  function automatic date_res_t add_days(input date_req_t r);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned n;
    int unsigned ml;
    bit          ovf;
    date_res_t   res;
    d   = r.day;
    m   = r.month;
    y   = r.year;
    n   = r.count;
    ovf = 1'b0;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    if (y == 0) y = 1;
    if (d == 0) d = 1;
    ml = days_in_month(m, y);
    if (d > ml) d = ml;
    if (n > DEF_MAX_ADD_DAYS) n = DEF_MAX_ADD_DAYS;
    while (n > 0 && !ovf) begin
      ml = days_in_month(m, y);
      if (n <= ml - d) begin
        d = d + n;
        n = 0;
      end else begin
        n = n - (ml - d + 1);
        d = 1;
        if (m == 12) begin
          m = 1;
          y++;
          if (y > YEAR_TOP) ovf = 1'b1;
        end else begin
          m++;
        end
      end
    end
    if (ovf) begin
      d = 31;
      m = 12;
      y = YEAR_TOP;
    end
    res.day   = DAY_W'(d);
    res.month = MONTH_W'(m);
    res.year  = YEAR_W'(y);
    res.ovf   = ovf;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // retire the oldest item before queuing a new one
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_dates.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected result %0d-%0d-%0d ovf=%0d", $realtime,
                     got.year, got.month, got.day, got.ovf);
        end else begin
          want = expected_dates.pop_front();
          req  = start_dates.pop_front();
          if (got.day !== want.day || got.month !== want.month ||
              got.year !== want.year || got.ovf !== want.ovf) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: %0d-%0d-%0d + %0d: expected %0d-%0d-%0d ovf=%0d, got %0d-%0d-%0d ovf=%0d",
                       $realtime, req.year, req.month, req.day, req.count,
                       want.year, want.month, want.day, want.ovf,
                       got.year, got.month, got.day, got.ovf);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_dates.push_back(add_days(in_data_i));
        start_dates.push_back(in_data_i);
      end
    end
    error_count_o <= errors;
    outstanding_o <= expected_dates.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dap_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 6000;
  localparam int unsigned HOLD_CYCLES      = 1000;
  localparam int unsigned DRAIN_CYCLES     = 400;
  localparam int unsigned RANDOM_PER_PHASE = 277;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned src_idle_pct  = 23;
  int unsigned sink_idle_pct = 57;
  bit          hold_req      = 1'b0;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  date_add_days i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  date_add_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [IN_W-1:0] pack_item(input int unsigned d, input int unsigned m,
                                                input int unsigned y, input int unsigned n);
    return {1'b0, ADD_W'(n), YEAR_W'(y), MONTH_W'(m), DAY_W'(d)};
  endfunction

  // called and returns at a falling edge; valid stays high into the next item
  task automatic offer_item(input logic [IN_W-1:0] item);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = item;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic offer_date(input int unsigned d, input int unsigned m,
                            input int unsigned y, input int unsigned n);
    offer_item(pack_item(d, m, y, n));
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // well-formed date, mostly long counts
      y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, 28);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 65535);
    end else if (pick < 75) begin
      // month and year ends around leap rules
      case ($urandom_range(0, 3))
        0:       y = 400 * $urandom_range(1, 40);
        1:       y = 100 * $urandom_range(1, 99);
        2:       y = 4 * $urandom_range(1, 2499);
        default: y = $urandom_range(1, 9999);
      endcase
      m = $urandom_range(0, 1) ? 2 : 12;
      d = $urandom_range(27, 31);
      n = $urandom_range(0, 400);
    end else if (pick < 85) begin
      // near the top year, often overflowing
      y = $urandom_range(16000, 16383);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, 31);
      n = $urandom_range(0, 65535);
    end else begin
      d = $urandom_range(0, 31);
      m = $urandom_range(0, 15);
      y = $urandom_range(0, 16383);
      n = $urandom_range(0, 65535);
    end
    offer_date(d, m, y, n);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: %0d cycles without a handshake", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    offer_date(1, 1, 1, 0);
    offer_date(31, 12, 9999, 1);
    offer_date(28, 2, 2023, 1);
    offer_date(28, 2, 2024, 1);
    offer_date(28, 2, 1900, 1);
    offer_date(28, 2, 2000, 1);
    offer_date(1, 1, 1, 65535);
    offer_date(31, 12, 16383, 1);
    offer_date(31, 12, 16383, 0);
    offer_date(1, 1, 16200, 65535);
    offer_date(15, 0, 2020, 10);
    offer_date(15, 13, 2020, 20);
    offer_date(31, 15, 2020, 1);
    offer_date(10, 6, 0, 400);
    offer_date(0, 3, 2021, 5);
    offer_date(31, 2, 2023, 0);
    offer_date(29, 2, 2023, 1);
    offer_date(31, 4, 2022, 0);
    offer_date(31, 1, 2024, 29);
    offer_date(1, 3, 2000, 365);
    offer_date(31, 12, 2099, 366);
    offer_date(31, 15, 16383, 65535);

    repeat (RANDOM_PER_PHASE) random_item();

    src_idle_pct  = 57;
    sink_idle_pct = 23;
    repeat (RANDOM_PER_PHASE) random_item();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // hold the receiver off while items keep coming
    s_axis_tvalid = 1'b0;
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    repeat (RANDOM_PER_PHASE) random_item();

    s_axis_tvalid = 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dap_pkg.sv
hw/rtl/dap_ctrl.sv
hw/rtl/dap_datapath.sv
hw/rtl/date_add_days.sv
tb/date_add_checker.sv
tb/tb_top.sv
